/* hw/rtl/pmx_pkg.sv */
package pmx_pkg;

  localparam int unsigned MAX_LENGTH = 64;
  localparam int unsigned MIN_LENGTH = 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned DEPTH      = 64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] first_parent_value;
    logic [IDX_W-1:0] second_parent_value;
    logic [CNT_W-1:0] cut_start;
    logic [CNT_W-1:0] cut_end;
  } pmx_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_position;
    logic [IDX_W-1:0] first_child_value;
    logic [IDX_W-1:0] second_child_value;
    logic             last;
  } pmx_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_RD,
    ST_SEG_WR,
    ST_MAP_RD,
    ST_MAP_V,
    ST_MAP_AT,
    ST_MAP_CHK,
    ST_CH_OWN,
    ST_CH_IDX,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_EMIT_RD,
    ST_EMIT_WR
  } pmx_state_t;

endpackage

/* hw/rtl/pmx_core.sv */
module pmx_core
  import pmx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] length_in_use,
  input  logic             in_valid,
  output logic             in_stall,
  input  pmx_in_t          in_item,
  output logic             res_valid,
  input  logic             res_stall,
  output pmx_out_t         res_item
);

  pmx_state_t state, state_next;

  logic             ch, ch_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] n, n_next;
  logic [CNT_W-1:0] s, s_next;
  logic [CNT_W-1:0] e, e_next;
  logic [CNT_W-1:0] steps, steps_next;
  logic [IDX_W-1:0] v, v_next;
  logic [IDX_W-1:0] at, at_next;
  logic [DEPTH-1:0] filled0, filled1;

  logic [IDX_W-1:0] fp_mem [DEPTH];
  logic [IDX_W-1:0] sp_mem [DEPTH];
  logic [IDX_W-1:0] fi_mem [DEPTH];
  logic [IDX_W-1:0] si_mem [DEPTH];
  logic [IDX_W-1:0] fc_mem [DEPTH];
  logic [IDX_W-1:0] sc_mem [DEPTH];

  logic [IDX_W-1:0] fp_q, sp_q, fi_q, si_q, fc_q, sc_q;
  logic [IDX_W-1:0] pa_addr, ia_addr, ca_addr;
  logic [IDX_W-1:0] own_q, other_q, own_idx_q, other_idx_q;

  logic             cw_en, fl_set, fl_clear;
  logic [IDX_W-1:0] cw_addr, cw_data;
  logic             ld_en, run_go;

  logic [CNT_W-1:0] nc, sc_cut, ec_cut;
  logic             cur_filled;

  assign own_q       = ch ? sp_q : fp_q;
  assign other_q     = ch ? fp_q : sp_q;
  assign own_idx_q   = ch ? si_q : fi_q;
  assign other_idx_q = ch ? fi_q : si_q;
  assign ca_addr     = i[IDX_W-1:0];
  assign cur_filled  = ch ? filled1[i[IDX_W-1:0]] : filled0[i[IDX_W-1:0]];

  assign ld_en  = (state == ST_IDLE) && in_valid && (in_item.command == CMD_LOAD);
  assign run_go = (state == ST_IDLE) && in_valid && (in_item.command == CMD_RUN);

  // clamp length and cut points; the cuts are ordered when a run starts in ST_IDLE
  always_comb begin
    nc = length_in_use;
    if (nc < CNT_W'(MIN_LENGTH)) nc = CNT_W'(MIN_LENGTH);
    if (nc > CNT_W'(MAX_LENGTH)) nc = CNT_W'(MAX_LENGTH);
    sc_cut = (in_item.cut_start > nc) ? nc : in_item.cut_start;
    ec_cut = (in_item.cut_end > nc) ? nc : in_item.cut_end;
  end

  always_ff @(posedge clk) begin
    fp_q <= fp_mem[pa_addr];
    sp_q <= sp_mem[pa_addr];
    fi_q <= fi_mem[ia_addr];
    si_q <= si_mem[ia_addr];
    fc_q <= fc_mem[ca_addr];
    sc_q <= sc_mem[ca_addr];
    if (ld_en) begin
      fp_mem[in_item.position] <= in_item.first_parent_value;
      sp_mem[in_item.position] <= in_item.second_parent_value;
      fi_mem[in_item.first_parent_value]  <= in_item.position;
      si_mem[in_item.second_parent_value] <= in_item.position;
    end
    if (cw_en && !ch) fc_mem[cw_addr] <= cw_data;
    if (cw_en && ch)  sc_mem[cw_addr] <= cw_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      filled0 <= '0;
      filled1 <= '0;
    end else begin
      state <= state_next;
      if (fl_clear) begin
        filled0 <= '0;
        filled1 <= '0;
      end else if (fl_set) begin
        if (ch) filled1[cw_addr] <= 1'b1;
        else    filled0[cw_addr] <= 1'b1;
      end
    end
    ch    <= ch_next;
    i     <= i_next;
    n     <= n_next;
    s     <= s_next;
    e     <= e_next;
    steps <= steps_next;
    v     <= v_next;
    at    <= at_next;
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    i_next     = i;
    n_next     = n;
    s_next     = s;
    e_next     = e;
    steps_next = steps;
    v_next     = v;
    at_next    = at;
    pa_addr    = i[IDX_W-1:0];
    ia_addr    = v;
    cw_en      = 1'b0;
    fl_set     = 1'b0;
    fl_clear   = 1'b0;
    cw_addr    = i[IDX_W-1:0];
    cw_data    = own_q;
    in_stall   = (state != ST_IDLE);
    res_valid  = 1'b0;
    res_item   = '{out_position: i[IDX_W-1:0], first_child_value: fc_q,
                   second_child_value: sc_q, last: (i == n - 1'b1)};

    case (state)
      ST_IDLE: begin
        if (run_go) begin
          n_next   = nc;
          s_next   = (sc_cut > ec_cut) ? ec_cut : sc_cut;
          e_next   = (sc_cut > ec_cut) ? sc_cut : ec_cut;
          i_next   = (sc_cut > ec_cut) ? ec_cut : sc_cut;
          ch_next  = 1'b0;
          fl_clear = 1'b1;
          state_next = ST_SEG_RD;
        end
      end
      // copy own parent's segment
      ST_SEG_RD: begin
        if (i == e) begin
          i_next = s;
          state_next = ST_MAP_RD;
        end else begin
          state_next = ST_SEG_WR;
        end
      end
      ST_SEG_WR: begin
        cw_en  = 1'b1;
        fl_set = 1'b1;
        i_next = i + 1'b1;
        state_next = ST_SEG_RD;
      end
      // place each missing value of the other segment
      ST_MAP_RD: begin
        if (i == e) begin
          i_next = '0;
          state_next = ST_FILL_RD;
        end else begin
          state_next = ST_MAP_V;
        end
      end
      ST_MAP_V: begin
        v_next  = other_q;
        ia_addr = other_q;
        state_next = ST_MAP_AT;
      end
      ST_MAP_AT: begin
        at_next = own_idx_q;
        pa_addr = own_idx_q;
        state_next = ST_MAP_CHK;
      end
      ST_MAP_CHK: begin
        if ({1'b0, at} >= s && {1'b0, at} < e && own_q == v) begin
          i_next = i + 1'b1;
          state_next = ST_MAP_RD;
        end else begin
          steps_next = '0;
          state_next = ST_CH_OWN;
        end
      end
      ST_CH_OWN: begin
        ia_addr    = own_q;
        steps_next = steps + 1'b1;
        state_next = ST_CH_IDX;
      end
      ST_CH_IDX: begin
        pa_addr = other_idx_q;
        if ({1'b0, other_idx_q} < s || {1'b0, other_idx_q} >= e) begin
          cw_en   = 1'b1;
          fl_set  = 1'b1;
          cw_addr = other_idx_q;
          cw_data = v;
          i_next  = i + 1'b1;
          state_next = ST_MAP_RD;
        end else if (steps == n) begin
          i_next = i + 1'b1;
          state_next = ST_MAP_RD;
        end else begin
          state_next = ST_CH_OWN;
        end
      end
      // fill remaining holes from the other parent
      ST_FILL_RD: begin
        if (i == n) begin
          if (!ch) begin
            ch_next = 1'b1;
            i_next  = s;
            state_next = ST_SEG_RD;
          end else begin
            i_next = '0;
            state_next = ST_EMIT_RD;
          end
        end else begin
          state_next = ST_FILL_WR;
        end
      end
      ST_FILL_WR: begin
        cw_en   = !cur_filled;
        cw_data = other_q;
        i_next  = i + 1'b1;
        state_next = ST_FILL_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          if (i == n - 1'b1) begin
            state_next = ST_IDLE;
          end else begin
            i_next = i + 1'b1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/pmx_permutation_crossover_top.sv */
// Load item: accepted while the core is idle, no result.
// Run item: per child, copy the own segment, place displaced values along the map chain,
//   fill the remaining holes, then emit the results; the single read port of each store sets the pace.
// One item is worked at a time; a waiting result sits in the output register.
// Synchronous active-high reset clears control and restores length_in_use to 64;
// parent and child stores hold garbage until written.
module pmx_permutation_crossover_top
  import pmx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  pmx_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output pmx_out_t         out_item
);

  logic [CNT_W-1:0] length_in_use;
  logic             res_valid, res_stall;
  pmx_out_t         res_item;

  // the register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= CNT_W'(MAX_LENGTH);
    end else if (cfg_valid) begin
      length_in_use <= cfg_data;
    end
  end

  pmx_core u_core (
    .clk           (clk),
    .rst           (rst),
    .length_in_use (length_in_use),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_item      (res_item)
  );

  // hold the core while the output register is full and stalled
  assign res_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && !res_stall) begin
      out_item <= res_item;
    end
  end

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pmx_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ITEM_TARGET    = 450;
  localparam int CALM_AFTER     = 380;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pmx_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pmx_out_t out_item;

  always #4 clk = ~clk;

  pmx_permutation_crossover_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Shadow copy of the block state, kept in step with accepted items.
  logic [IDX_W-1:0] first_parent [DEPTH];
  logic [IDX_W-1:0] second_parent[DEPTH];
  logic [IDX_W-1:0] first_where  [DEPTH];
  logic [IDX_W-1:0] second_where [DEPTH];
  logic [IDX_W-1:0] first_child  [DEPTH];
  logic [IDX_W-1:0] second_child [DEPTH];
  logic [CNT_W-1:0] length_reg = CNT_W'(MAX_LENGTH);

  pmx_out_t child_q[$];     // expected child positions, oldest first
  int       mismatches = 0;
  int       items_taken = 0;
  bit       calm = 1'b0;    // no idling once set

  // Build one child: own segment first, displaced values follow the map
  // chain out of the segment, remaining holes take the other parent.
  function automatic void build_child(input logic [IDX_W-1:0] own[DEPTH],
                                      input logic [IDX_W-1:0] other[DEPTH],
                                      input logic [IDX_W-1:0] own_idx[DEPTH],
                                      input logic [IDX_W-1:0] other_idx[DEPTH],
                                      ref logic [IDX_W-1:0] child[DEPTH],
                                      input int s, input int e, input int n);
    bit filled[DEPTH];
    logic [IDX_W-1:0] v, at, pos;
    int steps;
    bit left;
    for (int i = 0; i < DEPTH; i++) filled[i] = 1'b0;
    for (int i = s; i < e; i++) begin
      child[i] = own[i];
      filled[i] = 1'b1;
    end
    for (int i = s; i < e; i++) begin
      v = other[i];
      at = own_idx[v];
      if (at >= s && at < e && own[at] == v) continue;
      pos = IDX_W'(i);
      steps = 0;
      left = 1'b0;
      while (steps < n) begin
        pos = other_idx[own[pos]];
        steps++;
        if (pos < s || pos >= e) begin
          left = 1'b1;
          break;
        end
      end
      if (left) begin
        child[pos] = v;
        filled[pos] = 1'b1;
      end
    end
    for (int i = 0; i < n; i++)
      if (!filled[i]) child[i] = other[i];
  endfunction

  // Apply one accepted item to the shadow state; a run returns its children.
  function automatic void apply_item(input pmx_in_t it, ref pmx_out_t res[$]);
    int n, s, e, t;
    pmx_out_t r;
    res.delete();
    if (it.command == CMD_LOAD) begin
      first_parent[it.position]  = it.first_parent_value;
      second_parent[it.position] = it.second_parent_value;
      first_where[it.first_parent_value]   = it.position;
      second_where[it.second_parent_value] = it.position;
      return;
    end
    n = length_reg;
    if (n < MIN_LENGTH) n = MIN_LENGTH;
    if (n > MAX_LENGTH) n = MAX_LENGTH;
    s = it.cut_start;
    e = it.cut_end;
    if (s > n) s = n;
    if (e > n) e = n;
    if (s > e) begin
      t = s; s = e; e = t;
    end
    build_child(first_parent, second_parent, first_where, second_where,
                first_child, s, e, n);
    build_child(second_parent, first_parent, second_where, first_where,
                second_child, s, e, n);
    for (int i = 0; i < n; i++) begin
      r.out_position       = IDX_W'(i);
      r.first_child_value  = first_child[i];
      r.second_child_value = second_child[i];
      r.last               = (i == n - 1);
      res.push_back(r);
    end
  endfunction

  // Drive one item, optionally after an idle burst; predict on acceptance.
  // When ident is set, the run is checked against plain identity children.
  task automatic send_item(input pmx_in_t it, input bit ident = 1'b0);
    pmx_out_t res[$];
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_item(it, res);
    items_taken++;
    foreach (res[i]) begin
      if (ident) begin
        res[i].first_child_value  = res[i].out_position;
        res[i].second_child_value = res[i].out_position;
      end
      child_q.push_back(res[i]);
    end
    @(negedge clk);
  endtask

  // Write the length register with the block idle: drain results, then let
  // any trailing load finish.
  task automatic write_length(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    wait (child_q.size() == 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    length_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_pair(input int pos, input int a, input int b);
    pmx_in_t it;
    it = pmx_in_t'({$urandom, $urandom});
    it.command = CMD_LOAD;
    it.position = IDX_W'(pos);
    it.first_parent_value = IDX_W'(a);
    it.second_parent_value = IDX_W'(b);
    send_item(it);
  endtask

  task automatic run_cut(input int cs, input int ce, input bit ident = 1'b0);
    pmx_in_t it;
    it = pmx_in_t'({$urandom, $urandom});
    it.command = CMD_RUN;
    it.cut_start = CNT_W'(cs);
    it.cut_end = CNT_W'(ce);
    send_item(it, ident);
  endtask

  // Load fresh permutations of 0..n-1 at positions 0..n-1 in random order.
  task automatic load_parents(input int n);
    int pa[DEPTH], pb[DEPTH], order[DEPTH];
    int j, t;
    for (int i = 0; i < n; i++) begin
      pa[i] = i; pb[i] = i; order[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i); t = pa[i]; pa[i] = pa[j]; pa[j] = t;
      j = $urandom_range(0, i); t = pb[i]; pb[i] = pb[j]; pb[j] = t;
      j = $urandom_range(0, i); t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < n; i++) load_pair(order[i], pa[order[i]], pb[order[i]]);
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pmx_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (child_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        mismatches++;
      end else begin
        want = child_q.pop_front();
        if (out_item.out_position !== want.out_position ||
            out_item.first_child_value !== want.first_child_value ||
            out_item.second_child_value !== want.second_child_value ||
            out_item.last !== want.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
          mismatches++;
        end
      end
    end
  end

  // Receiver stalls in random bursts until the calm tail.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Directed rows: identity parents make the expected children readable.
  typedef struct {
    logic       command;
    int         pos, a, b, cs, ce;
    bit         ident;
  } step_row_t;

  step_row_t directed[] = '{
    '{CMD_RUN,   0,  0,  0,   0,   0, 1'b1},  // empty segment
    '{CMD_RUN,   0,  0,  0,   0,  64, 1'b1},  // whole range
    '{CMD_RUN,   0,  0,  0,  64,   0, 1'b1},  // cuts swapped
    '{CMD_RUN,   0,  0,  0, 127, 100, 1'b1},  // both cuts clamp to n
    '{CMD_RUN,   0,  0,  0,  20,  10, 1'b1},
    '{CMD_RUN,   0,  0,  0, 127,   0, 1'b1},
    '{CMD_LOAD,  0, 63,  0,   0,   0, 1'b0},  // swap 0 and 63 in first parent
    '{CMD_LOAD, 63,  0, 63,   0,   0, 1'b0},
    '{CMD_LOAD,  5, 17, 40,   0,   0, 1'b0},  // second parent 5<->40
    '{CMD_LOAD, 40, 40,  5,   0,   0, 1'b0},
    '{CMD_LOAD, 17,  5, 17,   0,   0, 1'b0},  // first parent 5<->17 swap
    '{CMD_RUN,   0,  0,  0,   0,  64, 1'b0},
    '{CMD_RUN,   0,  0,  0,   3,  45, 1'b0},
    '{CMD_RUN,   0,  0,  0,  41,   1, 1'b0},
    '{CMD_RUN,   0,  0,  0,  63,  64, 1'b0},
    '{CMD_RUN,   0,  0,  0,  30,  30, 1'b0}
  };

  initial begin
    int n, r, reps, cs, ce;
    pmx_in_t it;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every entry at the reset length so no run reads an unwritten one.
    for (int i = 0; i < DEPTH; i++) load_pair(i, i, i);
    foreach (directed[k]) begin
      if (directed[k].command == CMD_LOAD)
        load_pair(directed[k].pos, directed[k].a, directed[k].b);
      else
        run_cut(directed[k].cs, directed[k].ce, directed[k].ident);
    end

    // Random phases: new length, then well-formed load-and-run sequences
    // mixed with stray loads and skipped runs.
    while (items_taken < ITEM_TARGET) begin
      if (items_taken >= CALM_AFTER) calm = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 6)       n = $urandom_range(2, 8);
      else if (r < 8)  n = $urandom_range(9, 20);
      else if (r == 8) begin
        case ($urandom_range(0, 4))
          0: n = 0;
          1: n = 1;
          2: n = 2;
          3: n = 64;
          default: n = $urandom_range(65, 127);
        endcase
      end else n = $urandom_range(0, 127);
      write_length(CNT_W'(n));
      if (n < MIN_LENGTH) n = MIN_LENGTH;
      if (n > MAX_LENGTH) n = MAX_LENGTH;
      reps = (n > 20) ? 1 : $urandom_range(1, 4);
      repeat (reps) begin
        if ($urandom_range(0, 4) == 0) begin
          // stray loads: any position, any value
          repeat ($urandom_range(1, 3)) begin
            it = pmx_in_t'({$urandom, $urandom});
            it.command = CMD_LOAD;
            send_item(it);
          end
        end
        load_parents(n);
        if ($urandom_range(0, 5) == 0) continue;  // broken sequence: no run
        if ($urandom_range(0, 3) == 0) begin
          cs = $urandom_range(0, 127);
          ce = $urandom_range(0, 127);
        end else begin
          cs = $urandom_range(0, n);
          ce = $urandom_range(0, n);
        end
        run_cut(cs, ce);
      end
    end
    calm = 1'b1;
    in_valid <= 1'b0;

    wait (child_q.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
